@@ rtl/hbm_pkg.sv @@
// Shared types, codes and constants of the heartbeat health monitor.
package hbm_pkg;

    localparam int CHANNELS_DEF = 16;

    localparam int CMD_W      = 3;
    localparam int CHF_W      = 4;
    localparam int TIME_W     = 32;
    localparam int IVL_W      = 20;
    localparam int WIN_W      = 24;
    localparam int ATT_W      = 8;
    localparam int KIND_W     = 2;
    localparam int HLT_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 16;

    localparam logic [CMD_W-1:0] CMD_CHECK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CHECKIN  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_AUTO = 3'd2;
    localparam logic [CMD_W-1:0] CMD_START    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd6;

    localparam logic [KIND_W-1:0] KIND_FINAL   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EVENT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

    localparam logic [HLT_W-1:0] H_HEALTHY  = 2'd0;
    localparam logic [HLT_W-1:0] H_DEGRADED = 2'd1;
    localparam logic [HLT_W-1:0] H_CRITICAL = 2'd2;
    localparam logic [HLT_W-1:0] H_UNKNOWN  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX      = 2'd2;

    localparam logic [IVL_W-1:0] IVL_RST = 20'd1000;
    localparam logic [WIN_W-1:0] WIN_RST = 24'd60000;
    localparam logic [ATT_W-1:0] MAX_RST = 8'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CHECK,
        OP_START,
        OP_CHAN,
        OP_FINAL,
        OP_READ,
        OP_HEALTH,
        OP_RESTART,
        OP_NEXT
    } op_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             ch_valid;
        logic             tracked;
        logic             active;
        logic             scan_due;
        logic             crit;
        logic             auto_on;
        logic             event_need;
        logic             checkin_event;
        logic             restart_ok;
        logic             scan_last;
        logic             out_free;
    } stat_t;

endpackage

@@ rtl/hbm_dp.sv @@
// Datapath: item and config registers, per-channel store, scan arithmetic, output register.
module hbm_dp
    import hbm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  op_t                   op,
    output stat_t                 stat,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic [CMD_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic [KIND_W-1:0]     m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [CMD_W-1:0]  cmd_reg;
    logic [CHF_W-1:0]  ch_reg;
    logic [TIME_W-1:0] now_reg;
    logic              en_reg;
    logic [IVL_W+1:0]  thr3_reg;
    logic [TIME_W-1:0] since_reg;
    logic [TIME_W-1:0] wsince_reg;

    logic [IVL_W-1:0]  ivl_reg;
    logic [WIN_W-1:0]  win_reg;
    logic [ATT_W-1:0]  max_reg;
    logic [TIME_W-1:0] last_scan_reg;
    logic [IDX_W-1:0]  addr_reg;
    logic              removed_reg;

    logic [CHANNELS-1:0] trk_reg;
    logic [CHANNELS-1:0] run_reg;
    logic [CHANNELS-1:0] auto_reg;
    logic [TIME_W-1:0]   lci_reg  [CHANNELS];
    logic [TIME_W-1:0]   wb_reg   [CHANNELS];
    logic [HLT_W-1:0]    hlt_reg  [CHANNELS];
    logic [ATT_W-1:0]    att_reg  [CHANNELS];

    logic              m_valid_reg;
    logic [KIND_W-1:0] m_kind_reg;
    logic [CHF_W-1:0]  m_chan_reg;
    logic [HLT_W-1:0]  m_health_reg;
    logic              m_status_reg;
    logic [ATT_W-1:0]  m_attempt_reg;
    logic              m_last_reg;

    logic              trk_sel;
    logic              run_sel;
    logic              auto_sel;
    logic [TIME_W-1:0] lci_sel;
    logic [TIME_W-1:0] wb_sel;
    logic [HLT_W-1:0]  hlt_sel;
    logic [ATT_W-1:0]  att_sel;

    logic              ch_valid;
    logic              tracked;
    logic              crit;
    logic              deg;
    logic              wexp;
    logic [ATT_W-1:0]  att_eff;
    logic [ATT_W-1:0]  att_inc;
    logic              restart_ok;
    logic              event_need;
    logic [HLT_W-1:0]  new_hlt;
    logic              out_free;

    logic              emit;
    logic [KIND_W-1:0] e_kind;
    logic [CHF_W-1:0]  e_chan;
    logic [HLT_W-1:0]  e_health;
    logic              e_status;
    logic [ATT_W-1:0]  e_attempt;
    logic              e_last;

    assign trk_sel  = trk_reg[addr_reg];
    assign run_sel  = run_reg[addr_reg];
    assign auto_sel = auto_reg[addr_reg];
    assign lci_sel  = lci_reg[addr_reg];
    assign wb_sel   = wb_reg[addr_reg];
    assign hlt_sel  = hlt_reg[addr_reg];
    assign att_sel  = att_reg[addr_reg];

    assign ch_valid   = 32'(ch_reg) < CHANNELS;
    assign tracked    = ch_valid && trk_sel;
    assign crit       = since_reg > TIME_W'(thr3_reg);
    assign deg        = since_reg > TIME_W'(ivl_reg);
    assign wexp       = wsince_reg > TIME_W'(win_reg);
    assign att_eff    = wexp ? '0 : att_sel;
    assign att_inc    = att_eff + ATT_W'(1);
    assign restart_ok = att_eff < max_reg;
    assign event_need = (crit && (hlt_sel != H_CRITICAL))
                     || (!crit && deg && (hlt_sel != H_DEGRADED));
    assign new_hlt    = crit ? H_CRITICAL : H_DEGRADED;
    assign out_free   = !m_valid_reg || m_tready;

    always_comb
    begin
        stat.cmd           = cmd_reg;
        stat.ch_valid      = ch_valid;
        stat.tracked       = tracked;
        stat.active        = trk_sel && run_sel;
        stat.scan_due      = (now_reg - last_scan_reg) >= TIME_W'(ivl_reg);
        stat.crit          = crit;
        stat.auto_on       = auto_sel;
        stat.event_need    = event_need;
        stat.checkin_event = hlt_sel != H_HEALTHY;
        stat.restart_ok    = restart_ok;
        stat.scan_last     = addr_reg == IDX_W'(CHANNELS - 1);
        stat.out_free      = out_free;
    end

    always_comb
    begin
        emit      = 1'b0;
        e_kind    = KIND_FINAL;
        e_chan    = ch_reg;
        e_health  = H_HEALTHY;
        e_status  = 1'b0;
        e_attempt = '0;
        e_last    = 1'b0;
        case (op)
            OP_CHAN:
            begin
                emit   = (cmd_reg == CMD_CHECKIN) && (hlt_sel != H_HEALTHY);
                e_kind = KIND_EVENT;
            end
            OP_FINAL:
            begin
                emit   = 1'b1;
                e_last = 1'b1;
                if (cmd_reg == CMD_CHECK)
                begin
                    e_chan = '0;
                end
                else if (removed_reg)
                begin
                    e_health = H_UNKNOWN;
                end
                else if (!tracked)
                begin
                    e_health = H_UNKNOWN;
                    e_status = 1'b1;
                end
                else
                begin
                    e_health = hlt_sel;
                end
            end
            OP_HEALTH:
            begin
                emit     = event_need;
                e_kind   = KIND_EVENT;
                e_chan   = CHF_W'(addr_reg);
                e_health = new_hlt;
            end
            OP_RESTART:
            begin
                emit      = restart_ok;
                e_kind    = KIND_RESTART;
                e_chan    = CHF_W'(addr_reg);
                e_health  = H_CRITICAL;
                e_attempt = att_inc;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivl_reg       <= IVL_RST;
            win_reg       <= WIN_RST;
            max_reg       <= MAX_RST;
            last_scan_reg <= '0;
            addr_reg      <= '0;
            removed_reg   <= 1'b0;
            trk_reg       <= '0;
            run_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_INTERVAL: ivl_reg <= cfg_data[IVL_W-1:0];
                    REG_WINDOW:   win_reg <= cfg_data[WIN_W-1:0];
                    REG_MAX:      max_reg <= cfg_data[ATT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            case (op)
                OP_LOAD:
                begin
                    addr_reg    <= IDX_W'(s_tdata[CHF_W-1:0]);
                    removed_reg <= 1'b0;
                end
                OP_CHECK:
                begin
                    last_scan_reg <= now_reg;
                    addr_reg      <= '0;
                end
                OP_START:
                begin
                    trk_reg[addr_reg] <= 1'b1;
                    run_reg[addr_reg] <= 1'b1;
                end
                OP_CHAN:
                begin
                    if (cmd_reg == CMD_STOP)
                    begin
                        run_reg[addr_reg] <= 1'b0;
                    end
                    else if (cmd_reg == CMD_REMOVE)
                    begin
                        trk_reg[addr_reg] <= 1'b0;
                        run_reg[addr_reg] <= 1'b0;
                        removed_reg       <= 1'b1;
                    end
                end
                OP_NEXT:
                begin
                    addr_reg <= addr_reg + IDX_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_kind_reg    <= e_kind;
            m_chan_reg    <= e_chan;
            m_health_reg  <= e_health;
            m_status_reg  <= e_status;
            m_attempt_reg <= e_attempt;
            m_last_reg    <= e_last;
        end
        case (op)
            OP_LOAD:
            begin
                cmd_reg  <= s_tuser;
                ch_reg   <= s_tdata[CHF_W-1:0];
                now_reg  <= s_tdata[CHF_W+TIME_W-1:CHF_W];
                en_reg   <= s_tdata[CHF_W+TIME_W];
                thr3_reg <= {2'b00, ivl_reg} + {1'b0, ivl_reg, 1'b0};
            end
            OP_START:
            begin
                lci_reg[addr_reg]  <= now_reg;
                wb_reg[addr_reg]   <= now_reg;
                att_reg[addr_reg]  <= '0;
                hlt_reg[addr_reg]  <= H_HEALTHY;
                auto_reg[addr_reg] <= 1'b1;
            end
            OP_CHAN:
            begin
                if (cmd_reg == CMD_CHECKIN)
                begin
                    lci_reg[addr_reg] <= now_reg;
                    hlt_reg[addr_reg] <= H_HEALTHY;
                end
                else if (cmd_reg == CMD_SET_AUTO)
                begin
                    auto_reg[addr_reg] <= en_reg;
                end
            end
            OP_READ:
            begin
                since_reg  <= now_reg - lci_sel;
                wsince_reg <= now_reg - wb_sel;
            end
            OP_HEALTH:
            begin
                if (event_need)
                begin
                    hlt_reg[addr_reg] <= new_hlt;
                end
            end
            OP_RESTART:
            begin
                att_reg[addr_reg] <= restart_ok ? att_inc : att_eff;
                if (wexp)
                begin
                    wb_reg[addr_reg] <= now_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = m_kind_reg;
    assign m_tlast   = m_last_reg;
    assign m_tdata   = {1'b0, m_attempt_reg, m_status_reg, m_health_reg, m_chan_reg};

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result overwrote an untaken output");

    a_restart_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (m_kind_reg == KIND_RESTART))
        |-> ((m_health_reg == H_CRITICAL) && (m_attempt_reg != '0)))
        else $error("restart request with bad health or attempt");

    a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (m_last_reg == (m_kind_reg == KIND_FINAL)))
        else $error("last flag does not match final status");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_READ) |-> (32'(addr_reg) < CHANNELS))
        else $error("scan index beyond channel count");

endmodule

@@ rtl/hbm_ctrl.sv @@
// Controller: sequences command handling and the channel scan.
module hbm_ctrl
    import hbm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output op_t   op
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CHAN,
        ST_FINAL,
        ST_SCAN_RD,
        ST_SCAN_EVAL,
        ST_SCAN_RESTART,
        ST_SCAN_NEXT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && ready_reg)
                begin
                    op         = OP_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.cmd == CMD_CHECK)
                begin
                    if (stat.scan_due)
                    begin
                        op         = OP_CHECK;
                        state_next = ST_SCAN_RD;
                    end
                    else
                    begin
                        state_next = ST_FINAL;
                    end
                end
                else
                begin
                    if ((stat.cmd == CMD_START) && stat.ch_valid)
                    begin
                        op = OP_START;
                    end
                    state_next = ST_CHAN;
                end
            end
            ST_CHAN:
            begin
                if (!stat.tracked)
                begin
                    state_next = ST_FINAL;
                end
                else if (!((stat.cmd == CMD_CHECKIN) && stat.checkin_event && !stat.out_free))
                begin
                    op         = OP_CHAN;
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (stat.out_free)
                begin
                    op         = OP_FINAL;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN_RD:
            begin
                if (stat.active)
                begin
                    op         = OP_READ;
                    state_next = ST_SCAN_EVAL;
                end
                else if (stat.scan_last)
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    op = OP_NEXT;
                end
            end
            ST_SCAN_EVAL:
            begin
                if (!(stat.event_need && !stat.out_free))
                begin
                    op = OP_HEALTH;
                    if (stat.crit && stat.auto_on)
                    begin
                        state_next = ST_SCAN_RESTART;
                    end
                    else
                    begin
                        state_next = ST_SCAN_NEXT;
                    end
                end
            end
            ST_SCAN_RESTART:
            begin
                if (!(stat.restart_ok && !stat.out_free))
                begin
                    op         = OP_RESTART;
                    state_next = ST_SCAN_NEXT;
                end
            end
            ST_SCAN_NEXT:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    op         = OP_NEXT;
                    state_next = ST_SCAN_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= state_next == ST_IDLE;
        end
    end

    assign s_tready = ready_reg;

endmodule

@@ rtl/heartbeat_health_monitor_top.sv @@
// A channel command runs decode, its channel step and the final status; a check with no scan
// runs decode and final status. A scan skips idle channels, reads and evaluates running ones,
// with a restart step for critical ones with auto restart on. Throughput: one item at a time,
// set by the scan sequence. Output stalls hold it; a result waits in the output register while
// the next runs. Reset clears config to defaults, tracked and running bits, last scan time.
module heartbeat_health_monitor_top
    import hbm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_DATA_W-1:0]   s_axis_tdata,   // channel[3:0], now_ms[35:4], enable[36]
    input  logic [CMD_W-1:0]      s_axis_tuser,   // cmd[2:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_DATA_W-1:0]   m_axis_tdata,   // chan_out[3:0], health[5:4], status[6],
                                                  // attempt[14:7]
    output logic [KIND_W-1:0]     m_axis_tuser,   // kind[1:0]
    output logic                  m_axis_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    op_t   op;
    stat_t stat;

    hbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .stat     (stat),
        .op       (op)
    );

    hbm_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .stat      (stat),
        .s_tdata   (s_axis_tdata),
        .s_tuser   (s_axis_tuser),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .m_tuser   (m_axis_tuser),
        .m_tlast   (m_axis_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
